/* hdl/lqm_pkg.sv */
// ---------------------------------------------------------------------------
// lqm_pkg: shared constants for the linked queue manager
// Operation and status codes, fixed port widths and parameter defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lqm_pkg;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int QID_W    = 2;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 7;

  // Parameter defaults
  localparam int DEF_POOL_NODES = 64;
  localparam int DEF_NUM_QUEUES = 4;
  localparam int DEF_DATA_WIDTH = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
  localparam logic [OP_W-1:0] OP_CAT  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAME  = 2'd3;

endpackage

/* hdl/lqm_ram.sv */
// ---------------------------------------------------------------------------
// lqm_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/linked_queue_manager_with_splice_top.sv */
// ---------------------------------------------------------------------------
// linked_queue_manager_with_splice_top: linked-list FIFO queues, one node pool
// Enqueue, dequeue, peek and splice of whole queues over a shared node pool.
// ---------------------------------------------------------------------------
//
//  channel   ports                                        direction  transfer
//  --------  -------------------------------------------  ---------  ------------------
//  command   start busy op queue_id other_queue_id data_in  in       start && !busy
//  result    done data_out status queue_size queue_empty    out      done (one cycle)
//
//  Enqueue, same-queue splice and dequeue or peek of an empty queue end after
//  the queue table read; other dequeue, peek and splice go on to a second read,
//  of the node memory or of the source queue entry.
//  Reset is synchronous; valid bits cleared at reset and a fill pointer over
//  never-used nodes replace a clearing pass, so a command is taken at once.
//  The result shows for one cycle on done; the receiver cannot stall it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_queue_manager_with_splice_top #(
  parameter int POOL_NODES = lqm_pkg::DEF_POOL_NODES,
  parameter int NUM_QUEUES = lqm_pkg::DEF_NUM_QUEUES,
  parameter int DATA_WIDTH = lqm_pkg::DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [lqm_pkg::OP_W-1:0]          op,
  input  logic [lqm_pkg::QID_W-1:0]         queue_id,
  input  logic [lqm_pkg::QID_W-1:0]         other_queue_id,
  input  logic signed [DATA_WIDTH-1:0]      data_in,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      data_out,
  output logic [lqm_pkg::STATUS_W-1:0]      status,
  output logic [lqm_pkg::SIZE_W-1:0]        queue_size,
  output logic                              queue_empty
);

  localparam int NW   = $clog2(POOL_NODES);
  localparam int CW   = $clog2(POOL_NODES + 1);
  localparam int QW   = $clog2(NUM_QUEUES);
  localparam int QX_W = ((lqm_pkg::QID_W > QW) ? lqm_pkg::QID_W : QW) + 1;
  localparam int SZX  = CW + lqm_pkg::SIZE_W;
  localparam int QT_W = 2 * NW + CW;

  typedef struct packed {
    logic [NW-1:0] head;
    logic [NW-1:0] tail;
    logic [CW-1:0] cnt;
  } qent_t;

  typedef enum logic [1:0] {S_IDLE, S_QA, S_NODE, S_QB} state_t;

  // Control and context registers
  state_t                       state, state_next;
  logic [lqm_pkg::OP_W-1:0]     op_r;
  logic [QW-1:0]                qa_r, qb_r;
  logic [DATA_WIDTH-1:0]        din_r;
  logic [NW-1:0]                free_head, free_head_next;
  logic [CW-1:0]                free_count, free_count_next;
  logic [CW-1:0]                fresh_ptr, fresh_ptr_next;
  logic [NUM_QUEUES-1:0]        qvalid, qvalid_next;
  logic                         qt_ok;
  logic [NW-1:0]                ha, ta;
  logic [CW-1:0]                ca;
  logic                         latch_a;

  // Result next values
  logic                         done_next;
  logic [DATA_WIDTH-1:0]        dout_next;
  logic [lqm_pkg::STATUS_W-1:0] status_next;
  logic [CW-1:0]                fin_size;
  logic [SZX-1:0]               size_x;

  // Memory ports
  logic                         qt_we;
  logic [QW-1:0]                qt_waddr, qt_raddr;
  qent_t                        qt_wdata, qt_rdata, qt_rd;
  logic [QT_W-1:0]              qt_rbits;
  logic                         val_we;
  logic [NW-1:0]                val_waddr, val_raddr;
  logic [DATA_WIDTH-1:0]        val_wdata, val_rdata;
  logic                         link_we;
  logic [NW-1:0]                link_waddr, link_wdata, link_raddr, link_rdata;

  // Queue id reduction
  logic [QX_W-1:0]              qa_x, qb_x, qa_w, qb_w;
  logic [QW-1:0]                qa_in, qb_in;

  // Free list helpers
  logic                         fresh_hit;
  logic [NW-1:0]                head_plus1;
  logic [CW-1:0]                cnt_dec, cnt_sum;

  assign busy = (state != S_IDLE);

  // Fold identifiers into the queue range
  always_comb begin
    qa_x  = QX_W'(queue_id);
    qb_x  = QX_W'(other_queue_id);
    qa_w  = (qa_x >= QX_W'(NUM_QUEUES)) ? qa_x - QX_W'(NUM_QUEUES) : qa_x;
    qb_w  = (qb_x >= QX_W'(NUM_QUEUES)) ? qb_x - QX_W'(NUM_QUEUES) : qb_x;
    qa_in = qa_w[QW-1:0];
    qb_in = qb_w[QW-1:0];
  end

  // Queue table entry, zero when never written or spliced away
  assign qt_rdata = qent_t'(qt_rbits);
  assign qt_rd    = qt_ok ? qt_rdata : '0;

  // Free list: a node at the fill pointer was never used and links to n+1
  assign fresh_hit  = (CW'(free_head) == fresh_ptr);
  assign head_plus1 = (free_head == NW'(POOL_NODES - 1)) ? '0 : free_head + NW'(1);
  assign cnt_dec    = ca - CW'(1);

  // Read addresses
  always_comb begin
    case (state)
      S_IDLE:  qt_raddr = qa_in;
      S_QA:    qt_raddr = qb_r;
      default: qt_raddr = qa_r;
    endcase
    link_raddr = (state == S_QA) ? qt_rd.head : free_head;
    val_raddr  = qt_rd.head;
  end

  // Operation sequencing and memory writes
  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    free_count_next = free_count;
    fresh_ptr_next  = fresh_ptr;
    qvalid_next     = qvalid;
    latch_a         = 1'b0;
    done_next       = 1'b0;
    dout_next       = '0;
    status_next     = lqm_pkg::ST_OK;
    fin_size        = '0;
    cnt_sum         = ca + qt_rd.cnt;
    qt_we           = 1'b0;
    qt_waddr        = qa_r;
    qt_wdata        = '0;
    val_we          = 1'b0;
    val_waddr       = free_head;
    val_wdata       = din_r;
    link_we         = 1'b0;
    link_waddr      = qt_rd.tail;
    link_wdata      = free_head;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_QA;
        end
      end

      S_QA: begin
        case (op_r)
          lqm_pkg::OP_ENQ: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (free_count == '0) begin
              status_next = lqm_pkg::ST_FULL;
              fin_size    = qt_rd.cnt;
            end else begin
              // Take the head of the free list and append it
              val_we        = 1'b1;
              link_we       = (qt_rd.cnt != '0);
              qt_we         = 1'b1;
              qt_wdata.head = (qt_rd.cnt == '0) ? free_head : qt_rd.head;
              qt_wdata.tail = free_head;
              qt_wdata.cnt  = qt_rd.cnt + CW'(1);
              free_head_next  = fresh_hit ? head_plus1 : link_rdata;
              free_count_next = free_count - CW'(1);
              if (fresh_hit) begin
                fresh_ptr_next = fresh_ptr + CW'(1);
              end
              fin_size = qt_rd.cnt + CW'(1);
            end
          end
          lqm_pkg::OP_DEQ, lqm_pkg::OP_PEEK: begin
            if (qt_rd.cnt == '0) begin
              done_next   = 1'b1;
              status_next = lqm_pkg::ST_EMPTY;
              state_next  = S_IDLE;
            end else begin
              latch_a    = 1'b1;
              state_next = S_NODE;
            end
          end
          default: begin
            if (qa_r == qb_r) begin
              done_next   = 1'b1;
              status_next = lqm_pkg::ST_SAME;
              fin_size    = qt_rd.cnt;
              state_next  = S_IDLE;
            end else begin
              latch_a    = 1'b1;
              state_next = S_QB;
            end
          end
        endcase
      end

      S_NODE: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        dout_next  = val_rdata;
        if (op_r == lqm_pkg::OP_DEQ) begin
          // Unlink the head node and push it on the free list
          qt_we    = 1'b1;
          qt_wdata = (cnt_dec == '0) ? '0 : qent_t'{head: link_rdata, tail: ta, cnt: cnt_dec};
          link_we    = 1'b1;
          link_waddr = ha;
          link_wdata = free_head;
          free_head_next  = ha;
          free_count_next = free_count + CW'(1);
          fin_size = cnt_dec;
        end else begin
          fin_size = ca;
        end
      end

      S_QB: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        fin_size   = ca;
        if (ca != '0 && qt_rd.cnt != '0) begin
          // Splice the source list behind the destination tail
          link_we    = 1'b1;
          link_waddr = ta;
          link_wdata = qt_rd.head;
          qt_we      = 1'b1;
          qt_wdata   = qent_t'{head: ha, tail: qt_rd.tail, cnt: cnt_sum};
          qvalid_next[qb_r] = 1'b0;
          fin_size   = cnt_sum;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (qt_we) begin
      qvalid_next[qt_waddr] = 1'b1;
    end
  end

  assign size_x = SZX'(fin_size);

  // State, context and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op_r        <= lqm_pkg::OP_ENQ;
      qa_r        <= '0;
      qb_r        <= '0;
      din_r       <= '0;
      free_head   <= '0;
      free_count  <= CW'(POOL_NODES);
      fresh_ptr   <= '0;
      qvalid      <= '0;
      qt_ok       <= 1'b0;
      ha          <= '0;
      ta          <= '0;
      ca          <= '0;
      done        <= 1'b0;
      data_out    <= '0;
      status      <= lqm_pkg::ST_OK;
      queue_size  <= '0;
      queue_empty <= 1'b1;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      free_count <= free_count_next;
      fresh_ptr  <= fresh_ptr_next;
      qvalid     <= qvalid_next;
      qt_ok      <= qvalid[qt_raddr];
      if (state == S_IDLE && start) begin
        op_r  <= op;
        qa_r  <= qa_in;
        qb_r  <= qb_in;
        din_r <= data_in;
      end
      if (latch_a) begin
        ha <= qt_rd.head;
        ta <= qt_rd.tail;
        ca <= qt_rd.cnt;
      end
      done        <= done_next;
      data_out    <= dout_next;
      status      <= status_next;
      queue_size  <= size_x[lqm_pkg::SIZE_W-1:0];
      queue_empty <= (fin_size == '0);
    end
  end

  // Queue table: head, tail and count per queue
  lqm_ram #(
    .WIDTH(QT_W),
    .DEPTH(NUM_QUEUES)
  ) u_qtab (
    .clk  (clk),
    .we   (qt_we),
    .waddr(qt_waddr),
    .wdata(qt_wdata),
    .raddr(qt_raddr),
    .rdata(qt_rbits)
  );

  // Node values
  lqm_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(POOL_NODES)
  ) u_val (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(val_wdata),
    .raddr(val_raddr),
    .rdata(val_rdata)
  );

  // Node links
  lqm_ram #(
    .WIDTH(NW),
    .DEPTH(POOL_NODES)
  ) u_link (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  // A result only ends an operation in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an operation in flight");

  // An accepted command occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  // Pool full is reported only with an empty free list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == lqm_pkg::ST_FULL) |-> (free_count == '0))
    else $error("pool full reported with free nodes");

  // An empty queue error returns no data and an empty queue
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == lqm_pkg::ST_EMPTY) |-> (queue_empty && data_out == '0))
    else $error("empty queue result carries data");

endmodule

/* tb/linked_queue_manager_with_splice_checker.sv */
// ---------------------------------------------------------------------------
// linked_queue_manager_with_splice_checker: result predictor and comparator
// Watches the command and result channels of the queue manager. It keeps its
// own copy of the queue table, node pool and free list, works out the result
// of every accepted command, and compares each result field by field with the
// oldest prediction still pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_queue_manager_with_splice_checker #(
  parameter int POOL_NODES = lqm_pkg::DEF_POOL_NODES,
  parameter int NUM_QUEUES = lqm_pkg::DEF_NUM_QUEUES,
  parameter int DATA_WIDTH = lqm_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [lqm_pkg::OP_W-1:0]     op,
  input  logic [lqm_pkg::QID_W-1:0]    queue_id,
  input  logic [lqm_pkg::QID_W-1:0]    other_queue_id,
  input  logic signed [DATA_WIDTH-1:0] data_in,
  input  logic                         done,
  input  logic signed [DATA_WIDTH-1:0] data_out,
  input  logic [lqm_pkg::STATUS_W-1:0] status,
  input  logic [lqm_pkg::SIZE_W-1:0]   queue_size,
  input  logic                         queue_empty,
  output int                           mismatches,
  output int                           pending,
  output int                           results_checked,
  output int                           full_rejects,
  output int                           empty_rejects,
  output int                           self_splices,
  output int                           splices
);

  import lqm_pkg::*;

  localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int CNT_W  = $clog2(POOL_NODES + 1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] data;
    logic [STATUS_W-1:0]          stat;
    logic [SIZE_W-1:0]            size;
    logic                         empty;
  } queue_result_t;

  // Shadow copy of the queue table and node pool
  logic [NODE_W-1:0]           q_head [NUM_QUEUES];
  logic [NODE_W-1:0]           q_tail [NUM_QUEUES];
  logic [CNT_W-1:0]            q_count[NUM_QUEUES];
  logic signed [DATA_WIDTH-1:0] node_data[POOL_NODES];
  logic [NODE_W-1:0]           node_link[POOL_NODES];
  logic [NODE_W-1:0]           free_ptr;
  logic [CNT_W-1:0]            free_left;

  queue_result_t predicted_results[$];

  task automatic report_error(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic clear_pool();
    for (int q = 0; q < NUM_QUEUES; q++) begin
      q_head[q]  = '0;
      q_tail[q]  = '0;
      q_count[q] = '0;
    end
    for (int n = 0; n < POOL_NODES; n++) begin
      node_data[n] = '0;
      node_link[n] = NODE_W'((n + 1) % POOL_NODES);
    end
    free_ptr  = '0;
    free_left = CNT_W'(POOL_NODES);
  endtask

  // Apply one command to the shadow state and build its result
  task automatic apply_queue_op(input logic [OP_W-1:0] cmd, input int qa, input int qb,
                                input logic signed [DATA_WIDTH-1:0] value,
                                output queue_result_t res);
    logic [NODE_W-1:0] n;
    res.data = '0;
    res.stat = ST_OK;
    case (cmd)
      OP_ENQ: begin
        if (free_left == 0) begin
          res.stat = ST_FULL;
        end else begin
          n            = free_ptr;
          free_ptr     = node_link[n];
          free_left    = free_left - 1'b1;
          node_data[n] = value;
          if (q_count[qa] == 0) q_head[qa] = n;
          else node_link[q_tail[qa]] = n;
          q_tail[qa]  = n;
          q_count[qa] = q_count[qa] + 1'b1;
        end
      end
      OP_DEQ: begin
        if (q_count[qa] == 0) begin
          res.stat = ST_EMPTY;
        end else begin
          n           = q_head[qa];
          res.data    = node_data[n];
          q_head[qa]  = node_link[n];
          q_count[qa] = q_count[qa] - 1'b1;
          if (q_count[qa] == 0) begin
            q_head[qa] = '0;
            q_tail[qa] = '0;
          end
          // return the node to the front of the free list
          node_link[n] = free_ptr;
          free_ptr     = n;
          free_left    = free_left + 1'b1;
        end
      end
      OP_PEEK: begin
        if (q_count[qa] == 0) res.stat = ST_EMPTY;
        else res.data = node_data[q_head[qa]];
      end
      default: begin
        if (qa == qb) begin
          res.stat = ST_SAME;
        end else if (q_count[qa] != 0 && q_count[qb] != 0) begin
          // splice source list behind destination tail, then empty source
          node_link[q_tail[qa]] = q_head[qb];
          q_tail[qa]  = q_tail[qb];
          q_count[qa] = q_count[qa] + q_count[qb];
          q_head[qb]  = '0;
          q_tail[qb]  = '0;
          q_count[qb] = '0;
        end
      end
    endcase
    res.size  = SIZE_W'(q_count[qa]);
    res.empty = (q_count[qa] == 0);
  endtask

  // Compare results first, then predict the command taken at this edge
  always @(posedge clk) begin : watch
    queue_result_t want;
    if (rst) begin
      clear_pool();
      predicted_results.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (predicted_results.size() == 0) begin
          report_error("result strobe with no command pending");
        end else begin
          want = predicted_results.pop_front();
          results_checked++;
          if (data_out !== want.data)
            report_error($sformatf("data_out expected %0d got %0d", want.data, data_out));
          if (status !== want.stat)
            report_error($sformatf("status expected %0d got %0d", want.stat, status));
          if (queue_size !== want.size)
            report_error($sformatf("queue_size expected %0d got %0d", want.size, queue_size));
          if (queue_empty !== want.empty)
            report_error($sformatf("queue_empty expected %0d got %0d",
                                   want.empty, queue_empty));
        end
      end
      if (start && !busy) begin
        apply_queue_op(op, int'(queue_id) % NUM_QUEUES, int'(other_queue_id) % NUM_QUEUES,
                       data_in, want);
        if (want.stat == ST_FULL) full_rejects++;
        if (want.stat == ST_EMPTY) empty_rejects++;
        if (want.stat == ST_SAME) self_splices++;
        if (op == OP_CAT && want.stat == ST_OK) splices++;
        predicted_results.push_back(want);
      end
      pending <= predicted_results.size();
    end
  end

endmodule

/* tb/linked_queue_manager_with_splice_top_tb.sv */
// ---------------------------------------------------------------------------
// linked_queue_manager_with_splice_top_tb: stimulus and verdict
// Drives enqueue, dequeue, peek and splice commands into the queue manager:
// a directed opening over the corner cases, then random phases that fill the
// pool to overflow, drain it, or mix all operations, sent in bursts with
// random gaps. The checker beside the block predicts and compares results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_queue_manager_with_splice_top_tb;

  import lqm_pkg::*;

  localparam int DATA_WIDTH   = DEF_DATA_WIDTH;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} phase_mode_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [OP_W-1:0]              op = OP_ENQ;
  logic [QID_W-1:0]             queue_id = '0;
  logic [QID_W-1:0]             other_queue_id = '0;
  logic signed [DATA_WIDTH-1:0] data_in = '0;
  logic                         busy;
  logic                         done;
  logic signed [DATA_WIDTH-1:0] data_out;
  logic [STATUS_W-1:0]          status;
  logic [SIZE_W-1:0]            queue_size;
  logic                         queue_empty;

  int mismatches, pending, results_checked;
  int full_rejects, empty_rejects, self_splices, splices;
  int cycle_count = 0;
  int burst_left = 0;
  int sent = 0;

  linked_queue_manager_with_splice_top DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .queue_id       (queue_id),
    .other_queue_id (other_queue_id),
    .data_in        (data_in),
    .done           (done),
    .data_out       (data_out),
    .status         (status),
    .queue_size     (queue_size),
    .queue_empty    (queue_empty)
  );

  linked_queue_manager_with_splice_checker #(.DATA_WIDTH(DATA_WIDTH)) u_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .queue_id        (queue_id),
    .other_queue_id  (other_queue_id),
    .data_in         (data_in),
    .done            (done),
    .data_out        (data_out),
    .status          (status),
    .queue_size      (queue_size),
    .queue_empty     (queue_empty),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .full_rejects    (full_rejects),
    .empty_rejects   (empty_rejects),
    .self_splices    (self_splices),
    .splices         (splices)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Issue one command; start a new burst after a random gap when one ends
  task automatic send_cmd(input logic [OP_W-1:0] cmd, input int qa, input int qb,
                          input logic signed [DATA_WIDTH-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start          <= 1'b1;
    op             <= cmd;
    queue_id       <= QID_W'(qa);
    other_queue_id <= QID_W'(qb);
    data_in        <= value;
    // hold the command until the transfer
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Hold off until every predicted result has come back
  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return DATA_WIDTH'($urandom);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    phase_mode_t mode;
    int phase_len;
    int roll;
    int random_sent;
    logic [OP_W-1:0] cmd;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue errors, self splice, splices with an empty side,
    // data extremes, splice of two filled queues, drain back to empty
    send_cmd(OP_PEEK, 0, 0, '0);
    send_cmd(OP_DEQ, 0, 1, '0);
    send_cmd(OP_CAT, 1, 1, '0);
    send_cmd(OP_CAT, 0, 1, '0);
    send_cmd(OP_ENQ, 0, 0, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    send_cmd(OP_ENQ, 0, 0, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    send_cmd(OP_CAT, 0, 2, '0);
    send_cmd(OP_CAT, 2, 0, '0);
    send_cmd(OP_ENQ, 3, 0, '1);
    send_cmd(OP_ENQ, 3, 0, '0);
    send_cmd(OP_ENQ, 1, 3, 32'hAAAA_AAAA);
    send_cmd(OP_ENQ, 2, 3, 32'h5555_5555);
    send_cmd(OP_PEEK, 0, 3, '0);
    send_cmd(OP_CAT, 0, 3, '0);
    send_cmd(OP_PEEK, 3, 0, '0);
    send_cmd(OP_CAT, 3, 3, '0);
    send_cmd(OP_DEQ, 0, 0, '0);
    send_cmd(OP_DEQ, 0, 0, '0);
    send_cmd(OP_CAT, 1, 2, '0);
    send_cmd(OP_DEQ, 1, 0, '0);
    send_cmd(OP_CAT, 2, 1, '0);
    send_cmd(OP_DEQ, 0, 0, '0);
    send_cmd(OP_DEQ, 0, 0, '0);
    send_cmd(OP_DEQ, 1, 0, '0);
    send_cmd(OP_PEEK, 1, 0, '0);
    wait_drained();

    // Random phases: fill to overflow, drain, or mix everything
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mode = phase_mode_t'($urandom_range(0, 2));
      phase_len = (mode == MODE_FILL) ? $urandom_range(90, 130) : $urandom_range(30, 120);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  cmd = (roll < 85) ? OP_ENQ : (roll < 90) ? OP_DEQ :
                            (roll < 95) ? OP_PEEK : OP_CAT;
          MODE_DRAIN: cmd = (roll < 60) ? OP_DEQ : (roll < 75) ? OP_PEEK :
                            (roll < 90) ? OP_CAT : OP_ENQ;
          default:    cmd = (roll < 30) ? OP_ENQ : (roll < 60) ? OP_DEQ :
                            (roll < 80) ? OP_PEEK : OP_CAT;
        endcase
        send_cmd(cmd, $urandom_range(0, 3), $urandom_range(0, 3), pick_value());
        random_sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    // Wind down and let the last results arrive
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Summary: %0d commands sent (%0d random), %0d results checked",
             sent, random_sent, results_checked);
    $display("Summary: %0d pool-full, %0d empty-queue, %0d self-splice rejects; %0d splices",
             full_rejects, empty_rejects, self_splices, splices);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
